// ===== rtl/core/nct_pkg.sv =====
package nct_pkg;

    localparam int unsigned MaxTracksDef  = 32;
    localparam int unsigned MaxPendingDef = 32;
    localparam int unsigned CoordBitsDef  = 16;

    localparam int unsigned FieldW   = 16;
    localparam int unsigned IndexW   = 5;
    localparam int unsigned RadiusW  = 12;
    localparam int unsigned CountW   = 16;
    localparam int unsigned CfgIdxW  = 8;
    localparam int unsigned CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] RegMatchRadius  = 8'd0;
    localparam logic [CfgIdxW-1:0] RegConfirmCount = 8'd1;

    localparam logic [CountW-1:0] HitsMax = {CountW{1'b1}};

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_RD      = 12'b000000000010,
        S_DX      = 12'b000000000100,
        S_DY      = 12'b000000001000,
        S_DEC     = 12'b000000010000,
        S_CAND    = 12'b000000100000,
        S_CRD     = 12'b000001000000,
        S_CWR     = 12'b000010000000,
        S_PRD     = 12'b000100000000,
        S_PWR     = 12'b001000000000,
        S_DRD     = 12'b010000000000,
        S_DOUT    = 12'b100000000000
    } t_state;

endpackage

// ===== rtl/core/nct_ram.sv =====
module nct_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/nearest_centroid_tracker.sv =====
// nearest_centroid_tracker: frame based nearest neighbor tracking of blob centers.
// input channel (i_valid/o_ready): one item per detection, det_valid = 0 with
// frame_last = 1 closes a frame without a detection. o_ready is low while an
// item is being worked on; the block takes one item at a time.
// a detection scans all stored tracks through one shared squaring unit:
// a read, an x and a y step per stored track, then a decide step, then a
// candidate step when it matches. an idle item is taken without leaving the idle state.
// frame end: commit reads and writes back each used track, then reads and
// writes each queued detection (only a read when the queue is empty), then the
// dump sends one result per track in index order (entry_valid = 1, last on the
// final one), or a single marker with entry_valid = 0 when the table is empty.
// each dump result has a read and an output step and waits out any stall of i_ready.
// the output register holds the result while i_ready is low; the dump
// waits on it and nothing is lost.
// config channel (i_cfg_valid/o_cfg_ready): index 0 match_radius, index 1
// confirm_count, always ready; write only while idle.
// reset (synchronous, i_rst_n low) empties the table and the queue, clears
// the matched bits and the drop flag and loads the default registers.
// the track stores need no clearing pass: only written entries are read.
module nearest_centroid_tracker #(
    parameter int unsigned MAX_TRACKS  = nct_pkg::MaxTracksDef,
    parameter int unsigned MAX_PENDING = nct_pkg::MaxPendingDef,
    parameter int unsigned COORD_BITS  = nct_pkg::CoordBitsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [nct_pkg::FieldW-1:0]    i_det_x,
    input  logic [nct_pkg::FieldW-1:0]    i_det_y,
    input  logic                          i_det_valid,
    input  logic                          i_frame_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [nct_pkg::IndexW-1:0]    o_track_index,
    output logic [nct_pkg::FieldW-1:0]    o_track_x,
    output logic [nct_pkg::FieldW-1:0]    o_track_y,
    output logic [nct_pkg::CountW-1:0]    o_hit_count,
    output logic                          o_confirmed,
    output logic                          o_entry_valid,
    output logic                          o_overflow,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nct_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [nct_pkg::CfgDataW-1:0]  i_cfg_data
);
    import nct_pkg::*;

    localparam int unsigned PDEPTH = (MAX_PENDING > 1) ? MAX_PENDING : 2;
    localparam int unsigned TW   = $clog2(MAX_TRACKS);
    localparam int unsigned PW   = $clog2(PDEPTH);
    localparam int unsigned TCW  = $clog2(MAX_TRACKS + 1);
    localparam int unsigned PCW  = $clog2(MAX_PENDING + 1);
    localparam int unsigned SQW  = 2 * COORD_BITS;
    localparam int unsigned DW   = SQW + 1;
    localparam int unsigned R2W  = 2 * RadiusW;
    localparam int unsigned CMPW = (DW > R2W) ? DW : R2W;
    localparam int unsigned TRKW = 2 * COORD_BITS + CountW;
    localparam int unsigned CNDW = 2 * COORD_BITS + DW;
    localparam logic [TCW-1:0] TracksMax  = TCW'(MAX_TRACKS);
    localparam logic [PCW-1:0] PendingMax = PCW'(MAX_PENDING);

    t_state r_state, n_state;

    logic [RadiusW-1:0]    r_radius;
    logic [CountW-1:0]     r_confirm;
    logic [TCW-1:0]        r_used;
    logic [PCW-1:0]        r_pend;
    logic                  r_drop;
    logic [MAX_TRACKS-1:0] r_matched;
    logic [COORD_BITS-1:0] r_x, r_y;
    logic                  r_flast;
    logic [TCW-1:0]        r_i;
    logic [PCW-1:0]        r_j;
    logic [DW-1:0]         r_acc, r_best_d;
    logic [TW-1:0]         r_best;
    logic                  r_found;
    logic                  r_ovf;

    logic                  r_ovalid;
    logic [IndexW-1:0]     r_oidx;
    logic [FieldW-1:0]     r_ox, r_oy;
    logic [CountW-1:0]     r_ohits;
    logic                  r_oconf, r_oent, r_oovf, r_olast;

    // track table
    logic              trk_we;
    logic [TW-1:0]     trk_wa, trk_ra;
    logic [TRKW-1:0]   trk_wd, trk_rd;
    // candidates
    logic              cnd_we;
    logic [TW-1:0]     cnd_wa;
    logic [CNDW-1:0]   cnd_wd, cnd_rd;
    // queue
    logic              pnd_we;
    logic [PW-1:0]     pnd_wa, pnd_ra;
    logic [2*COORD_BITS-1:0] pnd_wd, pnd_rd;

    nct_ram #(.WIDTH(TRKW), .DEPTH(MAX_TRACKS)) u_trk (
        .i_clk(i_clk), .i_we(trk_we), .i_waddr(trk_wa), .i_wdata(trk_wd),
        .i_raddr(trk_ra), .o_rdata(trk_rd)
    );
    nct_ram #(.WIDTH(CNDW), .DEPTH(MAX_TRACKS)) u_cnd (
        .i_clk(i_clk), .i_we(cnd_we), .i_waddr(cnd_wa), .i_wdata(cnd_wd),
        .i_raddr(trk_ra), .o_rdata(cnd_rd)
    );
    nct_ram #(.WIDTH(2*COORD_BITS), .DEPTH(PDEPTH)) u_pnd (
        .i_clk(i_clk), .i_we(pnd_we), .i_waddr(pnd_wa), .i_wdata(pnd_wd),
        .i_raddr(pnd_ra), .o_rdata(pnd_rd)
    );

    logic [COORD_BITS-1:0] rd_x, rd_y;
    logic [CountW-1:0]     rd_hits;
    logic [COORD_BITS-1:0] c_x, c_y;
    logic [DW-1:0]         c_d;
    assign {rd_x, rd_y, rd_hits} = trk_rd;
    assign {c_x, c_y, c_d}       = cnd_rd;

    // shared squaring unit
    logic [COORD_BITS-1:0] sq_a, sq_b, sq_diff;
    logic [SQW-1:0]        sq_out;
    assign sq_diff = (sq_a > sq_b) ? sq_a - sq_b : sq_b - sq_a;
    assign sq_out  = SQW'(sq_diff) * SQW'(sq_diff);

    logic [R2W-1:0] r2;
    assign r2 = R2W'(r_radius) * R2W'(r_radius);

    logic [TW-1:0] trk_idx;
    logic [PW-1:0] que_idx;
    assign trk_idx = r_i[TW-1:0];
    assign que_idx = r_j[PW-1:0];

    logic out_free, out_load;
    assign out_free = !r_ovalid || i_ready;
    assign out_load = (r_state == S_DOUT) && out_free;

    logic scan_last, dump_last, is_match, cand_better;
    logic [CountW-1:0] hits_inc;
    t_state cmt_start;
    assign scan_last   = (r_i + TCW'(1) == r_used);
    assign dump_last   = (r_used == '0) || scan_last;
    assign is_match    = r_found && (CMPW'(r_best_d) <= CMPW'(r2));
    assign cand_better = !r_matched[r_best] || (r_best_d < c_d);
    assign hits_inc    = (rd_hits == HitsMax) ? rd_hits : rd_hits + CountW'(1);
    assign cmt_start   = (r_used == '0) ? S_PRD : S_CRD;

    always_comb begin
        sq_a = r_x;
        sq_b = rd_x;
        if (r_state == S_DY) begin
            sq_a = r_y;
            sq_b = rd_y;
        end
    end

    logic [DW-1:0] d_sum;
    assign d_sum = r_acc + DW'(sq_out);

    always_comb begin
        n_state = r_state;
        trk_we = 1'b0;
        trk_wa = trk_idx;
        trk_wd = {c_x, c_y, hits_inc};
        trk_ra = trk_idx;
        cnd_we = 1'b0;
        cnd_wa = r_best;
        cnd_wd = {r_x, r_y, r_best_d};
        pnd_we = 1'b0;
        pnd_wa = r_pend[PW-1:0];
        pnd_wd = {r_x, r_y};
        pnd_ra = que_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_det_valid) begin
                        n_state = (r_used == '0) ? S_DEC : S_RD;
                    end else if (i_frame_last) begin
                        n_state = cmt_start;
                    end
                end
            end
            S_RD:  n_state = S_DX;
            S_DX:  n_state = S_DY;
            S_DY:  n_state = scan_last ? S_DEC : S_RD;
            S_DEC: begin
                // fetch the held candidate of the nearest track
                trk_ra = r_best;
                if (is_match) begin
                    n_state = S_CAND;
                end else begin
                    pnd_we  = (r_pend < PendingMax);
                    n_state = r_flast ? cmt_start : S_IDLE;
                end
            end
            S_CAND: begin
                cnd_we  = cand_better;
                n_state = r_flast ? cmt_start : S_IDLE;
            end
            S_CRD: n_state = S_CWR;
            S_CWR: begin
                trk_we  = r_matched[trk_idx];
                n_state = scan_last ? S_PRD : S_CRD;
            end
            S_PRD: n_state = (r_pend == '0) ? S_DRD : S_PWR;
            S_PWR: begin
                trk_wa = r_used[TW-1:0];
                trk_wd = {pnd_rd, CountW'(1)};
                trk_we = (r_used < TracksMax);
                n_state = (r_j + PCW'(1) == r_pend) ? S_DRD : S_PRD;
            end
            S_DRD: n_state = S_DOUT;
            S_DOUT: begin
                if (out_free) begin
                    n_state = dump_last ? S_IDLE : S_DRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_radius  <= RadiusW'(800);
            r_confirm <= CountW'(10);
            r_used    <= '0;
            r_pend    <= '0;
            r_drop    <= 1'b0;
            r_matched <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= out_load || (r_ovalid && !i_ready);
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == RegMatchRadius) r_radius <= i_cfg_data[RadiusW-1:0];
                if (i_cfg_index == RegConfirmCount) r_confirm <= i_cfg_data[CountW-1:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_x     <= COORD_BITS'(i_det_x);
                        r_y     <= COORD_BITS'(i_det_y);
                        r_flast <= i_frame_last;
                    end
                    r_i     <= '0;
                    r_j     <= '0;
                    r_found <= 1'b0;
                end
                S_DX: r_acc <= DW'(sq_out);
                S_DY: begin
                    if (!r_found || d_sum < r_best_d) begin
                        r_best_d <= d_sum;
                        r_best   <= trk_idx;
                        r_found  <= 1'b1;
                    end
                    if (!scan_last) r_i <= r_i + TCW'(1);
                end
                S_DEC: begin
                    if (!is_match) begin
                        if (r_pend < PendingMax) r_pend <= r_pend + PCW'(1);
                        else r_drop <= 1'b1;
                    end
                    r_i <= '0;
                end
                S_CAND: begin
                    if (cand_better) r_matched[r_best] <= 1'b1;
                end
                S_CWR: begin
                    r_matched[trk_idx] <= 1'b0;
                    r_i <= scan_last ? '0 : r_i + TCW'(1);
                end
                S_PWR: begin
                    if (r_used < TracksMax) r_used <= r_used + TCW'(1);
                    else r_drop <= 1'b1;
                    if (r_j + PCW'(1) == r_pend) begin
                        r_pend <= '0;
                        r_j    <= '0;
                    end else begin
                        r_j <= r_j + PCW'(1);
                    end
                end
                S_DRD: begin
                    // overflow flag is captured once per dump
                    if (r_i == '0) begin
                        r_ovf  <= r_drop;
                        r_drop <= 1'b0;
                    end
                end
                S_DOUT: begin
                    if (out_free) begin
                        r_oidx <= IndexW'(r_i);
                        r_oovf <= r_ovf;
                        if (r_used == '0) begin
                            r_ox <= '0; r_oy <= '0; r_ohits <= '0;
                            r_oconf <= 1'b0; r_oent <= 1'b0; r_olast <= 1'b1;
                        end else begin
                            r_ox    <= FieldW'(rd_x);
                            r_oy    <= FieldW'(rd_y);
                            r_ohits <= rd_hits;
                            r_oconf <= rd_hits > r_confirm;
                            r_oent  <= 1'b1;
                            r_olast <= scan_last;
                        end
                        r_i <= r_i + TCW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_ovalid;
    assign o_track_index = r_oidx;
    assign o_track_x     = r_ox;
    assign o_track_y     = r_oy;
    assign o_hit_count   = r_ohits;
    assign o_confirmed   = r_oconf;
    assign o_entry_valid = r_oent;
    assign o_overflow    = r_oovf;
    assign o_last        = r_olast;

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= TracksMax) else $error("track count overflow");
    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PendingMax) else $error("queue overflow");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result lost");
endmodule
